// File: rtl/gcm_pkg.sv
// ============================================================================
// gcm_pkg
// Shared types and constants for the gradient colour map.
// ============================================================================
package gcm_pkg;

    // One packed stop; position sits in the top 16 bits.
    typedef struct packed {
        logic [15:0] pos;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } stop_t;

    // Classified word passed from the front end to the arithmetic back end.
    typedef struct packed {
        logic             in_range;
        logic [15:0]      span;
        logic [15:0]      offset;
        logic [2:0][15:0] cl;
        logic [2:0][15:0] cr;
    } work_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_STOP_COUNT = 3'd0;
    localparam logic [2:0] REG_STOP_FIRST = 3'd1;

    // Reset contents of the stop registers.
    localparam logic [2:0]  STOP_COUNT_RESET = 3'd2;
    localparam logic [63:0] STOP0_RESET      = 64'h0000_0000_0000_0000;
    localparam logic [63:0] STOP1_RESET      = 64'h8000_8000_8000_8000;
    localparam logic [63:0] STOPN_RESET      = 64'h0000_0000_0000_0000;

    localparam logic [7:0] CHAN_MAX = 8'hFF;

endpackage

// File: rtl/gcm_front.sv
// ============================================================================
// gcm_front
// Finds the first stop pair that brackets the position and gathers its data.
// ============================================================================
module gcm_front #(
    parameter int MAX_STOPS = 7
) (
    input  logic [15:0]                    position,
    input  logic [2:0]                     stop_count,
    input  gcm_pkg::stop_t [MAX_STOPS-1:0] stops,
    output gcm_pkg::work_t                 work
);
    import gcm_pkg::*;

    localparam int PAIRS = MAX_STOPS - 1;
    localparam int SW    = $clog2(PAIRS + 1);

    logic [2:0]         n_eff;
    logic [PAIRS-1:0]   hit;
    logic [SW-1:0]      sel;
    logic               any_hit;
    stop_t              left;
    stop_t              right;

    // Clamp the stop count to the supported range.
    always_comb
    begin
        if (stop_count < 3'd2)
            n_eff = 3'd2;
        else if (32'(stop_count) > MAX_STOPS)
            n_eff = 3'(MAX_STOPS);
        else
            n_eff = stop_count;
    end

    // Bracket test for every adjacent pair in parallel.
    always_comb
    begin
        for (int i = 0; i < PAIRS; i++)
        begin
            hit[i] = (32'(i + 1) < 32'(n_eff)) &&
                     (stops[i].pos <= position) && (position <= stops[i+1].pos);
        end
    end

    // The lowest bracketing pair wins.
    always_comb
    begin
        sel     = '0;
        any_hit = 1'b0;
        for (int i = PAIRS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                sel     = SW'(i);
                any_hit = 1'b1;
            end
        end
        left  = stops[sel];
        right = stops[SW'(sel + SW'(1))];
    end

    // A zero span behaves like a unit span at distance zero.
    always_comb
    begin
        work = '0;
        work.span = 16'd1;
        if (any_hit)
        begin
            work.in_range = 1'b1;
            if (right.pos != left.pos)
            begin
                work.span   = right.pos - left.pos;
                work.offset = position - left.pos;
            end
            work.cl[0] = left.red;
            work.cl[1] = left.green;
            work.cl[2] = left.blue;
            work.cr[0] = right.red;
            work.cr[1] = right.green;
            work.cr[2] = right.blue;
        end
    end

endmodule

// File: rtl/gcm_queue.sv
// ============================================================================
// gcm_queue
// Four-entry queue decoupling the front end from the back end.
// ============================================================================
module gcm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gcm_pkg::work_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output gcm_pkg::work_t head
);
    import gcm_pkg::*;

    work_t      mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;

    assign full  = (count_reg == 3'd4);
    assign empty = (count_reg == 3'd0);
    assign head  = mem[rd_ptr_reg];

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + 3'(push) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/gcm_back.sv
// ============================================================================
// gcm_back
// Interpolation products, scaling by 255 and a bit-per-stage divider.
// ============================================================================
module gcm_back #(
    parameter int FRAC_BITS = 15
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  gcm_pkg::work_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     red,
    output logic [7:0]     green,
    output logic [7:0]     blue,
    output logic           in_range
);
    import gcm_pkg::*;

    localparam int QW = 24 - FRAC_BITS;
    localparam int RW = 40 - FRAC_BITS;

    logic adv;

    // Stage one: products.
    logic                    p_val_reg;
    logic                    p_inr_reg;
    logic [15:0]             p_span_reg;
    logic [2:0][31:0]        p_m1_reg;
    logic [2:0][33:0]        p_m2_reg;

    // Stage two: scaled dividend.
    logic                    n_val_reg;
    logic                    n_inr_reg;
    logic [15:0]             n_span_reg;
    logic [2:0][RW-1:0]      n_rem_reg;
    logic [2:0][RW-1:0]      n_rem_next;

    // Divider stages.
    logic [QW-1:0]           d_val_reg;
    logic [QW-1:0]           d_inr_reg;
    logic [15:0]             d_span_reg [QW];
    logic [2:0][RW-1:0]      d_rem_reg  [QW];
    logic [2:0][QW-1:0]      d_q_reg    [QW];
    logic [2:0][RW-1:0]      d_rem_next [QW];
    logic [2:0][QW-1:0]      d_q_next   [QW];

    logic                    o_val_reg;
    logic                    o_inr_reg;
    logic [2:0][7:0]         o_ch_reg;
    logic [2:0][7:0]         o_ch_next;

    // The whole back end moves when the output register can take a word.
    assign adv       = !o_val_reg || out_ready;
    assign pop       = adv && !empty;
    assign out_valid = o_val_reg;
    assign red       = o_ch_reg[0];
    assign green     = o_ch_reg[1];
    assign blue      = o_ch_reg[2];
    assign in_range  = o_inr_reg;

    // Numerator sum, then times 255 and drop the fraction bits.
    always_comb
    begin
        logic signed [33:0] num;
        logic [39:0]        scaled;
        for (int c = 0; c < 3; c++)
        begin
            num = $signed({2'b00, p_m1_reg[c]}) + $signed(p_m2_reg[c]);
            scaled = {num[31:0], 8'd0} - {8'd0, num[31:0]};
            n_rem_next[c] = RW'(scaled >> FRAC_BITS);
        end
    end

    // One quotient bit per stage, most significant first.
    always_comb
    begin
        logic [RW-1:0] den;
        logic [RW-1:0] rem_in;
        logic [QW-1:0] q_in;
        int            jp;
        for (int j = 0; j < QW; j++)
        begin
            jp = (j == 0) ? 0 : j - 1;
            for (int c = 0; c < 3; c++)
            begin
                if (j == 0)
                begin
                    rem_in = n_rem_reg[c];
                    q_in   = '0;
                    den    = RW'(n_span_reg) << (QW - 1);
                end
                else
                begin
                    rem_in = d_rem_reg[jp][c];
                    q_in   = d_q_reg[jp][c];
                    den    = RW'(d_span_reg[jp]) << (QW - 1 - j);
                end
                d_rem_next[j][c] = rem_in;
                d_q_next[j][c]   = q_in;
                if (rem_in >= den)
                begin
                    d_rem_next[j][c]         = rem_in - den;
                    d_q_next[j][c][QW-1-j]   = 1'b1;
                end
            end
        end
    end

    // Saturate quotients above 255.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (d_q_reg[QW-1][c] > QW'(CHAN_MAX))
                o_ch_next[c] = CHAN_MAX;
            else
                o_ch_next[c] = d_q_reg[QW-1][c][7:0];
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_val_reg <= 1'b0;
            n_val_reg <= 1'b0;
            d_val_reg <= '0;
            o_val_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_val_reg <= !empty;
            n_val_reg <= p_val_reg;
            d_val_reg <= {d_val_reg[QW-2:0], n_val_reg};
            o_val_reg <= d_val_reg[QW-1];
        end
    end

    // Payload of every stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_inr_reg  <= head.in_range;
            p_span_reg <= head.span;
            for (int c = 0; c < 3; c++)
            begin
                p_m1_reg[c] <= head.cl[c] * head.span;
                p_m2_reg[c] <= 34'($signed({1'b0, head.offset}) *
                               ($signed({1'b0, head.cr[c]}) - $signed({1'b0, head.cl[c]})));
            end
            n_inr_reg  <= p_inr_reg;
            n_span_reg <= p_span_reg;
            n_rem_reg  <= n_rem_next;
            d_inr_reg[0]  <= n_inr_reg;
            d_span_reg[0] <= n_span_reg;
            for (int j = 1; j < QW; j++)
            begin
                d_inr_reg[j]  <= d_inr_reg[j-1];
                d_span_reg[j] <= d_span_reg[j-1];
            end
            for (int j = 0; j < QW; j++)
            begin
                d_rem_reg[j]  <= d_rem_next[j];
                d_q_reg[j]    <= d_q_next[j];
            end
            o_inr_reg <= d_inr_reg[QW-1];
            o_ch_reg  <= o_ch_next;
        end
    end

endmodule

// File: rtl/gradient_color_map.sv
// Path from an accepted word to m_tvalid: queue write, the product and scaled-dividend
// stages, 24 - FRAC_BITS divider stages, output register.
// Throughput: one word per clock while the output is not stalled; the divider takes one quotient bit per stage.
// A four-word queue lets the input side run while the output is stalled.
// Reset (rst_n, asynchronous): pipeline and queue empty, stop_count = 2,
// stop 0 black at 0.0, stop 1 white at 1.0, other stops zero.
// ============================================================================
// gradient_color_map
// Piecewise linear colour gradient over configurable stops.
// ============================================================================
module gradient_color_map #(
    parameter int MAX_STOPS = 7,
    parameter int FRAC_BITS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] position
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue, [24] in_range
);
    import gcm_pkg::*;

    logic [2:0]                 stop_count_reg;
    stop_t [MAX_STOPS-1:0]      stops_reg;
    work_t                      front_work;
    work_t                      head;
    logic                       q_full;
    logic                       q_empty;
    logic                       q_pop;
    logic [7:0]                 red;
    logic [7:0]                 green;
    logic [7:0]                 blue;
    logic                       in_range;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= STOP_COUNT_RESET;
            for (int i = 0; i < MAX_STOPS; i++)
                stops_reg[i] <= (i == 0) ? STOP0_RESET :
                                (i == 1) ? STOP1_RESET : STOPN_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_STOP_COUNT)
                stop_count_reg <= cfg_data[2:0];
            for (int i = 0; i < MAX_STOPS; i++)
                if (32'(cfg_index) == 32'(REG_STOP_FIRST) + i)
                    stops_reg[i] <= cfg_data;
        end
    end

    gcm_front #(.MAX_STOPS(MAX_STOPS)) u_front (
        .position   (s_tdata),
        .stop_count (stop_count_reg),
        .stops      (stops_reg),
        .work       (front_work)
    );

    assign s_tready = !q_full;

    gcm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && s_tready),
        .push_data (front_work),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (head)
    );

    gcm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (head),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .in_range  (in_range)
    );

    assign m_tdata = {7'd0, in_range, blue, green, red};

endmodule

// File: rtl/gcm_checker.sv
// ============================================================================
// gcm_checker
// Port-level checks for the gradient colour map.
// ============================================================================
module gcm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled output word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // A word out of range is black.
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[24] |-> m_tdata[23:0] == 24'd0)
        else $error("out-of-range word is not black");

    // Padding bits stay zero.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:25] == 7'd0)
        else $error("padding bits set");

endmodule

bind gradient_color_map gcm_checker u_gcm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: verif/tb_gradient_color_map.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_gradient_color_map
// Self-checking bench for the gradient colour map: positions are streamed in
// under varying gradients and each colour word is compared with a local model.
// ============================================================================
module tb_gradient_color_map;
    import gcm_pkg::*;

    localparam int FRAC = 15;
    localparam int NSTOPS_MAX = 7;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic       in_range;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } colour_t;

    // Gradient model and queue of predicted colours.
    class colour_board;
        logic [2:0]  count;
        logic [63:0] stops [NSTOPS_MAX];
        colour_t     pending [$];
        int          errors;
        int          checked;

        function new();
            count = STOP_COUNT_RESET;
            stops[0] = STOP0_RESET;
            stops[1] = STOP1_RESET;
            for (int i = 2; i < NSTOPS_MAX; i++)
                stops[i] = STOPN_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] val);
            if (idx == REG_STOP_COUNT)
                count = val[2:0];
            else
                stops[idx - REG_STOP_FIRST] = val;
        endfunction

        function logic [7:0] blend(longint cl, longint cr, longint d, longint span);
            longint q;
            if (span == 0)
                q = (255 * cl) >>> FRAC;
            else
                q = ((cl * span + d * (cr - cl)) * 255) / (span << FRAC);
            return (q > 255) ? 8'hFF : q[7:0];
        endfunction

        function void note_position(logic [15:0] p);
            colour_t c;
            stop_t l, r;
            int n;
            longint span, d;
            n = count;
            if (n < 2) n = 2;
            if (n > NSTOPS_MAX) n = NSTOPS_MAX;
            c = '0;
            for (int i = 0; i + 1 < n; i++)
            begin
                l = stops[i];
                r = stops[i + 1];
                if (l.pos <= p && p <= r.pos)
                begin
                    span = r.pos - l.pos;
                    d = p - l.pos;
                    c.red = blend(l.red, r.red, d, span);
                    c.green = blend(l.green, r.green, d, span);
                    c.blue = blend(l.blue, r.blue, d, span);
                    c.in_range = 1'b1;
                    break;
                end
            end
            pending = {pending, c};
        endfunction

        function void check_colour(logic [31:0] word);
            colour_t got, want;
            got = word[24:0];
            if (pending.size() == 0)
            begin
                $error("unexpected colour word %h", word);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.red !== want.red)
            begin
                $error("red: expected %0d, actual %0d", want.red, got.red);
                errors++;
            end
            if (got.green !== want.green)
            begin
                $error("green: expected %0d, actual %0d", want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue)
            begin
                $error("blue: expected %0d, actual %0d", want.blue, got.blue);
                errors++;
            end
            if (got.in_range !== want.in_range)
            begin
                $error("in_range: expected %0d, actual %0d", want.in_range, got.in_range);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    colour_board board;
    int send_idle;   // percentage of cycles the sender holds off
    int recv_stall;  // percentage of cycles the receiver stalls
    int cycles;
    int sent;

    gradient_color_map dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit guard.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver: random stalls and checking of every accepted colour word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                board.check_colour(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Writes one configuration register while the block is idle.
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        board.set_reg(idx, val);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Sends one position word, holding it until it is taken. Valid stays high
    // afterwards so that words can follow back to back.
    task automatic send_position(logic [15:0] p);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge clk); while (!s_tready);
        board.note_position(p);
        sent++;
    endtask

    // Stops sending and lets the pipeline drain completely.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [63:0] make_stop(logic [15:0] pos, bit wild);
        stop_t s;
        s.pos = pos;
        s.red = wild ? 16'($urandom) : 16'($urandom_range(32768));
        s.green = wild ? 16'($urandom) : 16'($urandom_range(32768));
        s.blue = wild ? 16'($urandom) : 16'($urandom_range(32768));
        return s;
    endfunction

    // Loads a random gradient; mostly sorted, sometimes unsorted or over range.
    task automatic setup_gradient(int n);
        logic [15:0] pos;
        int kind;
        kind = $urandom_range(9);
        pos = (kind < 5) ? 16'd0 : 16'($urandom_range(4000));
        write_reg(REG_STOP_COUNT, 64'(n));
        for (int i = 0; i < NSTOPS_MAX; i++)
        begin
            if (kind == 9)
                pos = 16'($urandom);
            else if (i > 0)
                pos = (pos > 16'hFFFF - 16'd20000) ? pos :
                      pos + 16'($urandom_range(($urandom_range(4) == 0) ? 0 : 20000));
            write_reg(3'(REG_STOP_FIRST + i), make_stop(pos, kind == 8));
        end
    endtask

    task automatic random_positions(int num);
        stop_t s;
        for (int k = 0; k < num; k++)
        begin
            if ($urandom_range(3) == 0)
            begin
                s = board.stops[$urandom_range(NSTOPS_MAX - 1)];
                send_position(s.pos + 16'($urandom_range(2)) - 16'd1);
            end
            else if ($urandom_range(1) == 0)
                send_position(16'($urandom_range(45000)));
            else
                send_position(16'($urandom));
        end
    endtask

    initial
    begin
        int phase_idle [4];
        int phase_stall [4];
        board = new();
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_STOP_COUNT;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle = 0;
        recv_stall = 0;
        sent = 0;
        phase_idle = '{0, 67, 0, 13};
        phase_stall = '{0, 0, 67, 13};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset gradient at its edges and beyond 1.0.
        send_position(16'h0000);
        send_position(16'h0001);
        send_position(16'h4000);
        send_position(16'h7FFF);
        send_position(16'h8000);
        send_position(16'h8001);
        send_position(16'hFFFF);
        send_position(16'h5555);
        send_position(16'hAAAA);
        drain();

        // Zero span, saturation above 1.0 and unsorted pair; count below 2.
        write_reg(REG_STOP_COUNT, 64'd0);
        write_reg(3'd1, {16'h1000, 16'hFFFF, 16'h8000, 16'h0000});
        write_reg(3'd2, {16'h1000, 16'h0000, 16'hFFFF, 16'h4000});
        send_position(16'h1000);
        send_position(16'h0FFF);
        send_position(16'h1001);
        drain();
        write_reg(REG_STOP_COUNT, 64'd7);
        write_reg(3'd1, {16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        write_reg(3'd2, {16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF});
        write_reg(3'd3, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
        write_reg(3'd4, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
        write_reg(3'd5, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
        write_reg(3'd6, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
        write_reg(3'd7, {16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_position(16'h0000);
        send_position(16'hFFFF);
        send_position(16'h8000);
        send_position(16'h0001);
        drain();

        // Random gradients across the idling phases, counts from 0 to 7.
        for (int g = 0; g < 24; g++)
        begin
            send_idle = phase_idle[g % 4];
            recv_stall = phase_stall[g % 4];
            setup_gradient((g < 8) ? g : $urandom_range(7));
            random_positions(62);
            drain();
        end

        $display("Covered %0d positions over 27 gradients; %0d colour words checked.",
                 sent, board.checked);
        $display("Stop counts 0 to 7, zero spans, saturation and unsorted stops exercised.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
